// ===== hw/rtl/eac_pkg.sv =====
// shared types and constants for the email address syntax checker
package eac_pkg;

	// counter width and saturation value for position and domain count
	localparam int unsigned CntW = 7;
	localparam logic [CntW-1:0] CNT_MAX = 7'd127;

	// configuration register widths, indexes and reset values
	localparam int unsigned CfgW = 7;
	localparam int unsigned CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] CFG_LOCAL_MAX_INDEX = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_DOMAIN_MAX_COUNT = 1'b1;
	localparam logic [CfgW-1:0] LOCAL_MAX_INDEX_RST = 7'd64;
	localparam logic [CfgW-1:0] DOMAIN_MAX_COUNT_RST = 7'd63;

	// characters with a role of their own
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_AT = 8'h40;
	localparam logic [7:0] CH_DASH = 8'h2D;

	// classification of one character
	typedef struct packed {
		logic is_dot;
		logic is_at;
		logic local_ok;
		logic domain_ok;
	} char_class_t;

	// configuration seen by the tracker
	typedef struct packed {
		logic [CfgW-1:0] local_max_index;
		logic [CfgW-1:0] domain_max_count;
	} cfg_t;

endpackage

// ===== hw/rtl/eac_char_class.sv =====
// character classifier: legal local and domain characters, dot and at sign
module eac_char_class (
	input  logic [7:0]          char_code,
	output eac_pkg::char_class_t cls
);

	logic alnum;
	logic special;

	// letters and digits
	always_comb begin
		case (char_code) inside
			[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]: alnum = 1'b1;
			default: alnum = 1'b0;
		endcase
	end

	// specials allowed before the at sign: . - @ ! # $ % & ' * + / = ? ^ _ ` { | } ~
	always_comb begin
		case (char_code) inside
			8'h21, [8'h23:8'h27], 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h2F,
			8'h3D, 8'h3F, 8'h40, 8'h5E, 8'h5F, 8'h60, [8'h7B:8'h7E]: special = 1'b1;
			default: special = 1'b0;
		endcase
	end

	// class flags
	always_comb begin
		cls.is_dot    = (char_code == eac_pkg::CH_DOT);
		cls.is_at     = (char_code == eac_pkg::CH_AT);
		cls.local_ok  = alnum | special;
		cls.domain_ok = alnum | (char_code == eac_pkg::CH_DOT) |
			(char_code == eac_pkg::CH_DASH) | (char_code == eac_pkg::CH_AT);
	end

endmodule

// ===== hw/rtl/eac_track.sv =====
// per-address state tracker: rule checks, counters and the verdict
module eac_track (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 last,
	input  eac_pkg::char_class_t cls,
	input  eac_pkg::cfg_t        cfg,
	output logic                 verdict
);

	logic [eac_pkg::CntW-1:0] position_q;
	logic [eac_pkg::CntW-1:0] domain_count_q;
	logic                     at_seen_q;
	logic                     prev_was_dot_q;
	logic                     failed_q;

	logic                     at_now;
	logic [eac_pkg::CntW:0]   dcount_inc;
	logic                     fail_next;
	logic [eac_pkg::CntW-1:0] dcount_next;
	logic [eac_pkg::CntW-1:0] position_next;

	// rule checks for the current character
	always_comb begin
		at_now     = at_seen_q | cls.is_at;
		dcount_inc = {1'b0, domain_count_q} + {{eac_pkg::CntW{1'b0}}, 1'b1};
		fail_next  = failed_q
			| ((position_q == '0) & (cls.is_at | cls.is_dot))
			| (last & cls.is_dot)
			| (cls.is_dot & prev_was_dot_q)
			| (cls.is_at & (at_seen_q | last))
			| (at_now & (dcount_inc > {1'b0, cfg.domain_max_count}))
			| (~at_now & (position_q > cfg.local_max_index))
			| (at_now ? ~cls.domain_ok : ~cls.local_ok);
		verdict = ~fail_next & at_now;
	end

	// saturating counters
	always_comb begin
		if (!at_now) begin
			dcount_next = domain_count_q;
		end else if (dcount_inc > {1'b0, eac_pkg::CNT_MAX}) begin
			dcount_next = eac_pkg::CNT_MAX;
		end else begin
			dcount_next = dcount_inc[eac_pkg::CntW-1:0];
		end
		if (position_q < eac_pkg::CNT_MAX) begin
			position_next = position_q + {{(eac_pkg::CntW-1){1'b0}}, 1'b1};
		end else begin
			position_next = position_q;
		end
	end

	// state update, cleared after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q     <= '0;
			domain_count_q <= '0;
			at_seen_q      <= 1'b0;
			prev_was_dot_q <= 1'b0;
			failed_q       <= 1'b0;
		end else if (step) begin
			if (last) begin
				position_q     <= '0;
				domain_count_q <= '0;
				at_seen_q      <= 1'b0;
				prev_was_dot_q <= 1'b0;
				failed_q       <= 1'b0;
			end else begin
				position_q     <= position_next;
				domain_count_q <= dcount_next;
				at_seen_q      <= at_now;
				prev_was_dot_q <= cls.is_dot;
				failed_q       <= fail_next;
			end
		end
	end

`ifndef SYNTHESIS
	// state is back at reset values after the last character
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> position_q == '0 && !at_seen_q && !failed_q &&
			domain_count_q == '0)
		else $error("tracker state not cleared after last character");

	// domain count only runs once the at sign is seen
	a_dcount_needs_at: assert property (@(posedge clk) disable iff (!arst_n)
		domain_count_q != '0 |-> at_seen_q)
		else $error("domain count without at sign");

	// an at sign seen means at least one character went by
	a_at_needs_position: assert property (@(posedge clk) disable iff (!arst_n)
		at_seen_q |-> position_q != '0 && domain_count_q != '0)
		else $error("at sign flagged at position zero");
`endif

endmodule

// ===== hw/rtl/email_address_syntax_checker.sv =====
// top level: input register, character checks and verdict register
// Checks the syntax of an email address fed one character per transfer, with
// is_last on the final character. A character is taken every cycle unless a
// blocked result stalls input; a character classifier and small saturating
// counters sit between the input and result registers. The verdict registers as
// the last character leaves stage 1; the next address may follow at once. Only
// the last character of an address produces a result transfer. The user must
// write the two limit registers through cfg while no address is open; unenforced.
module email_address_syntax_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [eac_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [eac_pkg::CfgW-1:0]    cfg_data,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [7:0]                  char_code,
	input  logic                        is_last,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        address_valid
);

	eac_pkg::cfg_t        cfg_q;
	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 last_s1;
	logic                 advance;
	logic                 verdict;
	eac_pkg::char_class_t cls;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_max_index  <= eac_pkg::LOCAL_MAX_INDEX_RST;
			cfg_q.domain_max_count <= eac_pkg::DOMAIN_MAX_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				eac_pkg::CFG_LOCAL_MAX_INDEX:  cfg_q.local_max_index  <= cfg_data;
				eac_pkg::CFG_DOMAIN_MAX_COUNT: cfg_q.domain_max_count <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves on unless it holds a last character with the result slot blocked
	assign advance    = valid_s1 & (~last_s1 | ~result_valid | ~result_stall);
	assign item_stall = valid_s1 & ~advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	eac_char_class u_class (
		.char_code (char_s1),
		.cls       (cls)
	);

	eac_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.last    (last_s1),
		.cls     (cls),
		.cfg     (cfg_q),
		.verdict (verdict)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && last_s1) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			address_valid <= verdict;
		end
	end

`ifndef SYNTHESIS
	// input stalls only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && last_s1 && result_valid && result_stall)
		else $error("input stalled without a blocked result");

	// a new result always comes from a last character leaving stage 1
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(advance && last_s1))
		else $error("result without a last character");

	// a blocked result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> !(advance && last_s1))
		else $error("pending result overwritten");
`endif

endmodule
